// ===== hdl/single_wire_sensor_reader_core_defines.svh =====
// Assertion macros shared by the sensor reader RTL.
`ifndef SINGLE_WIRE_SENSOR_READER_CORE_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_READER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SWSR_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define SWSR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define SWSR_ASSERT_IMPL(label, clk, rst_n, cond, expr)
`define SWSR_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== hdl/swsr_pkg.sv =====
`timescale 1ns / 1ps

package swsr_pkg;

    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int FRAME_W = 4;
    localparam int BYTE_W = 8;
    localparam int BIT_IDX_W = 3;
    localparam int DRIVE_W = 2;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int MAX_FRAME_BYTES_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_PROBE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TIMEOUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 3'd6;

    localparam logic [CFG_W-1:0] START_LOW_RST = 16'd1300;
    localparam logic [CFG_W-1:0] DRIVE_HIGH_RST = 16'd30;
    localparam logic [CFG_W-1:0] RESP_PROBE_RST = 16'd40;
    localparam logic [CFG_W-1:0] RESP_HIGH_RST = 16'd80;
    localparam logic [CFG_W-1:0] BIT_SAMPLE_RST = 16'd40;
    localparam logic [CFG_W-1:0] EDGE_TIMEOUT_RST = 16'd2000;
    localparam logic [FRAME_W-1:0] FRAME_BYTES_RST = 4'd5;

    localparam logic [DRIVE_W-1:0] DRIVE_RELEASE = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_LOW = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_HIGH = 2'd2;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_LOW        = 4'd1,
        PH_HIGH       = 4'd2,
        PH_PROBE      = 4'd3,
        PH_RESP_HIGH  = 4'd4,
        PH_RESP_FALL  = 4'd5,
        PH_BIT_RISE   = 4'd6,
        PH_BIT_SAMPLE = 4'd7,
        PH_BIT_FALL   = 4'd8
    } phase_t;

endpackage

// ===== hdl/single_wire_sensor_reader_core.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_stall   mode, line_level
// out       out_valid / out_stall drive, byte_valid, byte_value, last_byte,
//                                 done_res, response_ok, busy_res
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken per clock cycle while in_stall is low; its result appears in the next cycle.
// The rate is set by the update of the phase, timer and byte state for each request.
// Reset returns to idle with all timing registers at their default values.
// A stalled result is held in the output register; a new request is taken in
// the same cycle that the held result leaves, so in_stall follows out_stall.
`timescale 1ns / 1ps
`include "single_wire_sensor_reader_core_defines.svh"

module single_wire_sensor_reader_core #(
    parameter int TIMER_WIDTH = swsr_pkg::TIMER_WIDTH_DEF,
    parameter int MAX_FRAME_BYTES = swsr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic                                line_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [swsr_pkg::DRIVE_W-1:0]        drive,
    output logic                                byte_valid,
    output logic [swsr_pkg::BYTE_W-1:0]         byte_value,
    output logic                                last_byte,
    output logic                                done_res,
    output logic                                response_ok,
    output logic                                busy_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swsr_pkg::CFG_W-1:0]          cfg_data
);
    import swsr_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH + 1 > CFG_W + 1) ? TIMER_WIDTH + 1 : CFG_W + 1;
    localparam logic [TIMER_WIDTH-1:0] TIMER_LAST = {{(TIMER_WIDTH - 1){1'b1}}, 1'b0};
    localparam logic [FRAME_W-1:0] FRAME_MAX = FRAME_W'(MAX_FRAME_BYTES);
    localparam logic [FRAME_W-1:0] FRAME_MIN = FRAME_W'(1);

    logic [CFG_W-1:0] start_low_reg, drive_high_reg, resp_probe_reg;
    logic [CFG_W-1:0] resp_high_reg, bit_sample_reg, edge_timeout_reg;
    logic [FRAME_W-1:0] frame_bytes_reg;

    phase_t phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [BIT_IDX_W-1:0] bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [FRAME_W-1:0] byte_count_reg, byte_count_next;
    logic response_seen_reg, response_seen_next;

    logic out_valid_reg;
    logic [DRIVE_W-1:0] drive_reg, drive_next;
    logic byte_valid_reg, byte_valid_next;
    logic [BYTE_W-1:0] byte_value_reg, byte_value_next;
    logic last_byte_reg, last_byte_next;
    logic done_res_reg, done_res_next;
    logic response_ok_reg;
    logic busy_res_reg, busy_res_next;

    logic in_accept;
    logic [CFG_W-1:0] phase_len;
    logic [CMP_W-1:0] count;
    logic elapsed;
    logic [TIMER_WIDTH-1:0] tick_timer;
    logic [FRAME_W-1:0] frame_len;
    logic [FRAME_W-1:0] byte_count_inc;

    assign in_stall = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= START_LOW_RST;
            drive_high_reg <= DRIVE_HIGH_RST;
            resp_probe_reg <= RESP_PROBE_RST;
            resp_high_reg <= RESP_HIGH_RST;
            bit_sample_reg <= BIT_SAMPLE_RST;
            edge_timeout_reg <= EDGE_TIMEOUT_RST;
            frame_bytes_reg <= FRAME_BYTES_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_LOW:    start_low_reg <= cfg_data;
                REG_DRIVE_HIGH:   drive_high_reg <= cfg_data;
                REG_RESP_PROBE:   resp_probe_reg <= cfg_data;
                REG_RESP_HIGH:    resp_high_reg <= cfg_data;
                REG_BIT_SAMPLE:   bit_sample_reg <= cfg_data;
                REG_EDGE_TIMEOUT: edge_timeout_reg <= cfg_data;
                REG_FRAME_BYTES:  frame_bytes_reg <= cfg_data[FRAME_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_LOW:        phase_len = start_low_reg;
            PH_HIGH:       phase_len = drive_high_reg;
            PH_PROBE:      phase_len = resp_probe_reg;
            PH_RESP_HIGH:  phase_len = resp_high_reg;
            PH_BIT_SAMPLE: phase_len = bit_sample_reg;
            default:       phase_len = edge_timeout_reg;
        endcase
    end

    // A phase also ends when the timer would reach its all-ones value.
    assign count = CMP_W'(timer_reg) + CMP_W'(1);
    assign elapsed = (count >= CMP_W'(phase_len)) || (timer_reg == TIMER_LAST);
    assign tick_timer = elapsed ? '0 : count[TIMER_WIDTH-1:0];

    assign frame_len = (frame_bytes_reg == '0) ? FRAME_MIN :
                       (frame_bytes_reg > FRAME_MAX) ? FRAME_MAX : frame_bytes_reg;
    assign byte_count_inc = byte_count_reg + FRAME_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_count_next = bit_count_reg;
        shift_next = shift_reg;
        byte_count_next = byte_count_reg;
        response_seen_next = response_seen_reg;
        byte_valid_next = 1'b0;
        byte_value_next = '0;
        last_byte_next = 1'b0;
        done_res_next = 1'b0;
        if (mode)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next = PH_LOW;
                timer_next = '0;
                bit_count_next = '0;
                shift_next = '0;
                byte_count_next = '0;
                response_seen_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    timer_next = tick_timer;
                    if (elapsed)
                    begin
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    timer_next = tick_timer;
                    if (elapsed)
                    begin
                        phase_next = PH_PROBE;
                    end
                end
                PH_PROBE:
                begin
                    timer_next = tick_timer;
                    if (elapsed)
                    begin
                        if (!line_level)
                        begin
                            phase_next = PH_RESP_HIGH;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done_res_next = 1'b1;
                        end
                    end
                end
                PH_RESP_HIGH:
                begin
                    timer_next = tick_timer;
                    if (elapsed)
                    begin
                        if (line_level)
                        begin
                            response_seen_next = 1'b1;
                            phase_next = PH_RESP_FALL;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done_res_next = 1'b1;
                        end
                    end
                end
                PH_RESP_FALL:
                begin
                    if (!line_level || elapsed)
                    begin
                        timer_next = '0;
                        bit_count_next = '0;
                        byte_count_next = '0;
                        phase_next = PH_BIT_RISE;
                    end
                    else
                    begin
                        timer_next = tick_timer;
                    end
                end
                PH_BIT_RISE:
                begin
                    if (line_level || elapsed)
                    begin
                        timer_next = '0;
                        phase_next = PH_BIT_SAMPLE;
                    end
                    else
                    begin
                        timer_next = tick_timer;
                    end
                end
                PH_BIT_SAMPLE:
                begin
                    timer_next = tick_timer;
                    if (elapsed)
                    begin
                        shift_next[LAST_BIT - bit_count_reg] = line_level;
                        phase_next = PH_BIT_FALL;
                    end
                end
                PH_BIT_FALL:
                begin
                    if (!line_level || elapsed)
                    begin
                        timer_next = '0;
                        if (bit_count_reg == LAST_BIT)
                        begin
                            byte_valid_next = 1'b1;
                            byte_value_next = shift_reg;
                            byte_count_next = byte_count_inc;
                            bit_count_next = '0;
                            if (byte_count_inc >= frame_len)
                            begin
                                last_byte_next = 1'b1;
                                done_res_next = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_BIT_RISE;
                            end
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + BIT_IDX_W'(1);
                            phase_next = PH_BIT_RISE;
                        end
                    end
                    else
                    begin
                        timer_next = tick_timer;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_LOW:  drive_next = DRIVE_LOW;
            PH_HIGH: drive_next = DRIVE_HIGH;
            default: drive_next = DRIVE_RELEASE;
        endcase
        busy_res_next = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_count_reg <= '0;
            shift_reg <= '0;
            byte_count_reg <= '0;
            response_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                bit_count_reg <= bit_count_next;
                shift_reg <= shift_next;
                byte_count_reg <= byte_count_next;
                response_seen_reg <= response_seen_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            drive_reg <= drive_next;
            byte_valid_reg <= byte_valid_next;
            byte_value_reg <= byte_value_next;
            last_byte_reg <= last_byte_next;
            done_res_reg <= done_res_next;
            response_ok_reg <= response_seen_next;
            busy_res_reg <= busy_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive = drive_reg;
    assign byte_valid = byte_valid_reg;
    assign byte_value = byte_value_reg;
    assign last_byte = last_byte_reg;
    assign done_res = done_res_reg;
    assign response_ok = response_ok_reg;
    assign busy_res = busy_res_reg;

    // The last byte of a frame always ends the transaction.
    `SWSR_ASSERT_IMPL(a_last_ends, clk, rst_n, out_valid_reg && last_byte_reg, byte_valid_reg && done_res_reg)
    // A finished transaction leaves the block idle.
    `SWSR_ASSERT_IMPL(a_done_idle, clk, rst_n, out_valid_reg && done_res_reg, !busy_res_reg)
    // The line is only driven while a transaction runs.
    `SWSR_ASSERT_IMPL(a_drive_busy, clk, rst_n, out_valid_reg && drive_reg != DRIVE_RELEASE, busy_res_reg)
    // An accepted start from idle always begins with the low pulse.
    `SWSR_ASSERT_NEXT(a_start_low, clk, rst_n, in_accept && mode && phase_reg == PH_IDLE, phase_reg == PH_LOW)

endmodule

// ===== verif/single_wire_sensor_reader_core_tb.sv =====
`timescale 1ns / 1ps

module single_wire_sensor_reader_core_tb;
    import swsr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {
        LINE_CLEAN,
        LINE_NOISE,
        LINE_STUCK,
        LINE_HELD_LOW,
        LINE_HELD_HIGH
    } line_style_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               byte_valid;
        logic [BYTE_W-1:0]  byte_value;
        logic               last_byte;
        logic               done_res;
        logic               response_ok;
        logic               busy_res;
    } sensor_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 mode = 1'b0;
    logic                 line_level = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DRIVE_W-1:0]   drive;
    logic                 byte_valid;
    logic [BYTE_W-1:0]    byte_value;
    logic                 last_byte;
    logic                 done_res;
    logic                 response_ok;
    logic                 busy_res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    single_wire_sensor_reader_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .line_level  (line_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .byte_valid  (byte_valid),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .done_res    (done_res),
        .response_ok (response_ok),
        .busy_res    (busy_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the reader: registers and transaction state.
    logic [CFG_W-1:0]     timing_reg [0:5];
    logic [FRAME_W-1:0]   frame_reg;
    phase_t               rd_phase;
    logic [CFG_W-1:0]     rd_timer;
    logic [BIT_IDX_W-1:0] rd_bit;
    logic [BYTE_W-1:0]    rd_shift;
    logic [FRAME_W-1:0]   rd_bytes;
    logic                 rd_resp;

    sensor_result_t expected_results[$];
    sensor_result_t seen_exp;
    int             err_count = 0;
    logic           calm = 1'b0;
    int             hold_id = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    task automatic reset_reader_model();
        timing_reg[REG_START_LOW] = START_LOW_RST;
        timing_reg[REG_DRIVE_HIGH] = DRIVE_HIGH_RST;
        timing_reg[REG_RESP_PROBE] = RESP_PROBE_RST;
        timing_reg[REG_RESP_HIGH] = RESP_HIGH_RST;
        timing_reg[REG_BIT_SAMPLE] = BIT_SAMPLE_RST;
        timing_reg[REG_EDGE_TIMEOUT] = EDGE_TIMEOUT_RST;
        frame_reg = FRAME_BYTES_RST;
        rd_phase = PH_IDLE;
        rd_timer = '0;
        rd_bit = '0;
        rd_shift = '0;
        rd_bytes = '0;
        rd_resp = 1'b0;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        if (idx <= REG_EDGE_TIMEOUT)
            timing_reg[idx] = data;
        else if (idx == REG_FRAME_BYTES)
            frame_reg = data[FRAME_W-1:0];
    endfunction

    function automatic logic phase_elapsed(input logic [CFG_W-1:0] len);
        logic [CFG_W:0] cnt;
        cnt = {1'b0, rd_timer} + 1'b1;
        if (cnt >= {1'b0, len} || cnt >= {1'b0, {TIMER_WIDTH_DEF{1'b1}}})
        begin
            rd_timer = '0;
            return 1'b1;
        end
        rd_timer = cnt[CFG_W-1:0];
        return 1'b0;
    endfunction

    function automatic void enter_phase(input phase_t p);
        rd_phase = p;
        rd_timer = '0;
    endfunction

    function automatic logic [FRAME_W-1:0] frame_limit();
        logic [FRAME_W-1:0] n;
        n = frame_reg;
        if (n == 0)
            n = FRAME_W'(1);
        if (n > MAX_FRAME_BYTES_DEF)
            n = FRAME_W'(MAX_FRAME_BYTES_DEF);
        return n;
    endfunction

    function automatic sensor_result_t advance_reader(input logic m, input logic ln);
        sensor_result_t r;
        r = '0;
        if (m)
        begin
            if (rd_phase == PH_IDLE)
            begin
                enter_phase(PH_LOW);
                rd_bit = '0;
                rd_shift = '0;
                rd_bytes = '0;
                rd_resp = 1'b0;
            end
        end
        else
        begin
            case (rd_phase)
                PH_LOW:
                    if (phase_elapsed(timing_reg[REG_START_LOW]))
                        enter_phase(PH_HIGH);
                PH_HIGH:
                    if (phase_elapsed(timing_reg[REG_DRIVE_HIGH]))
                        enter_phase(PH_PROBE);
                PH_PROBE:
                    if (phase_elapsed(timing_reg[REG_RESP_PROBE]))
                    begin
                        if (!ln)
                            enter_phase(PH_RESP_HIGH);
                        else
                        begin
                            enter_phase(PH_IDLE);
                            r.done_res = 1'b1;
                        end
                    end
                PH_RESP_HIGH:
                    if (phase_elapsed(timing_reg[REG_RESP_HIGH]))
                    begin
                        if (ln)
                        begin
                            rd_resp = 1'b1;
                            enter_phase(PH_RESP_FALL);
                        end
                        else
                        begin
                            enter_phase(PH_IDLE);
                            r.done_res = 1'b1;
                        end
                    end
                PH_RESP_FALL:
                    if (!ln || phase_elapsed(timing_reg[REG_EDGE_TIMEOUT]))
                    begin
                        rd_bit = '0;
                        rd_bytes = '0;
                        enter_phase(PH_BIT_RISE);
                    end
                PH_BIT_RISE:
                    if (ln || phase_elapsed(timing_reg[REG_EDGE_TIMEOUT]))
                        enter_phase(PH_BIT_SAMPLE);
                PH_BIT_SAMPLE:
                    if (phase_elapsed(timing_reg[REG_BIT_SAMPLE]))
                    begin
                        rd_shift[LAST_BIT - rd_bit] = ln;
                        enter_phase(PH_BIT_FALL);
                    end
                PH_BIT_FALL:
                    if (!ln || phase_elapsed(timing_reg[REG_EDGE_TIMEOUT]))
                    begin
                        if (rd_bit == LAST_BIT)
                        begin
                            r.byte_valid = 1'b1;
                            r.byte_value = rd_shift;
                            rd_bytes = rd_bytes + 1'b1;
                            rd_bit = '0;
                            if (rd_bytes >= frame_limit())
                            begin
                                r.last_byte = 1'b1;
                                r.done_res = 1'b1;
                                enter_phase(PH_IDLE);
                            end
                            else
                                enter_phase(PH_BIT_RISE);
                        end
                        else
                        begin
                            rd_bit = rd_bit + 1'b1;
                            enter_phase(PH_BIT_RISE);
                        end
                    end
                default:
                    enter_phase(PH_IDLE);
            endcase
        end
        if (rd_phase == PH_LOW)
            r.drive = DRIVE_LOW;
        else if (rd_phase == PH_HIGH)
            r.drive = DRIVE_HIGH;
        else
            r.drive = DRIVE_RELEASE;
        r.response_ok = rd_resp;
        r.busy_res = (rd_phase != PH_IDLE);
        return r;
    endfunction

    // Line level a sensor would show in the current phase, or a disturbed one.
    function automatic logic pick_line(input line_style_t st);
        logic rnd;
        rnd = 1'($urandom_range(1));
        if (st == LINE_NOISE)
            return rnd;
        if (st == LINE_HELD_LOW)
            return 1'b0;
        if (st == LINE_HELD_HIGH)
            return 1'b1;
        case (rd_phase)
            PH_PROBE:
                return 1'b0;
            PH_RESP_HIGH:
                return 1'b1;
            PH_RESP_FALL, PH_BIT_FALL:
                return (st == LINE_STUCK) ? 1'b1 : ($urandom_range(3) == 0);
            PH_BIT_RISE:
                return (st == LINE_STUCK) ? 1'b0 : ($urandom_range(3) != 0);
            default:
                return rnd;
        endcase
    endfunction

    function automatic line_style_t pick_style();
        int r;
        r = $urandom_range(19);
        if (r < 15)
            return LINE_CLEAN;
        if (r < 17)
            return LINE_NOISE;
        if (r < 18)
            return LINE_STUCK;
        if (r < 19)
            return LINE_HELD_LOW;
        return LINE_HELD_HIGH;
    endfunction

    task automatic push_sample(input logic m, input logic ln);
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        line_level <= ln;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(advance_reader(m, ln));
    endtask

    task automatic wait_results_idle();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] sl, input logic [CFG_W-1:0] dh,
                              input logic [CFG_W-1:0] rp, input logic [CFG_W-1:0] rh,
                              input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] to,
                              input logic [CFG_W-1:0] fb);
        wait_results_idle();
        write_reg(REG_START_LOW, sl);
        write_reg(REG_DRIVE_HIGH, dh);
        write_reg(REG_RESP_PROBE, rp);
        write_reg(REG_RESP_HIGH, rh);
        write_reg(REG_BIT_SAMPLE, bs);
        write_reg(REG_EDGE_TIMEOUT, to);
        write_reg(REG_FRAME_BYTES, fb);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_ticks(input line_style_t st, input int max_ticks);
        int n;
        n = 0;
        while (rd_phase != PH_IDLE && n < max_ticks)
        begin
            if ($urandom_range(99) < 3)
                push_sample(1'b1, 1'($urandom_range(1)));
            else
                push_sample(1'b0, pick_line(st));
            n++;
        end
    endtask

    task automatic run_frame(input line_style_t st, input int max_ticks);
        push_sample(1'b1, 1'($urandom_range(1)));
        run_ticks(st, max_ticks);
    endtask

    task automatic test_idle_ticks();
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b0);
    endtask

    task automatic test_default_frame();
        run_frame(LINE_CLEAN, 40);
        // The start pulse is still running; shorter values finish the frame.
        set_timing(2, 2, 2, 2, 2, 4, 1);
        run_ticks(LINE_CLEAN, 500);
    endtask

    task automatic test_start_while_busy();
        set_timing(2, 2, 2, 2, 2, 4, 1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        run_ticks(LINE_CLEAN, 500);
    endtask

    task automatic test_failed_response();
        set_timing(2, 1, 3, 2, 1, 4, 2);
        run_frame(LINE_HELD_HIGH, 100);
        run_frame(LINE_HELD_LOW, 100);
    endtask

    task automatic test_zero_delays();
        set_timing(0, 0, 0, 0, 0, 0, 16'hFFF0);
        run_frame(LINE_STUCK, 500);
        run_frame(LINE_CLEAN, 500);
        run_frame(LINE_NOISE, 500);
    endtask

    task automatic test_frame_clamp();
        set_timing(1, 0, 1, 0, 1, 0, 15);
        run_frame(LINE_CLEAN, 2000);
    endtask

    task automatic test_register_extremes();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000F);
        push_sample(1'b1, 1'b1);
        repeat (20) push_sample(1'b0, pick_line(LINE_CLEAN));
        wait_results_idle();
        write_reg(REG_UNUSED, 16'h5A5A);
        write_reg(REG_UNUSED, 16'hA5A5);
        // The transaction is still in its start pulse; new values apply at once.
        set_timing(3, 2, 1, 2, 1, 3, 2);
        run_ticks(LINE_CLEAN, 3000);
    endtask

    task automatic test_random_traffic();
        int          ph;
        int          k;
        line_style_t st;
        st = LINE_CLEAN;
        for (ph = 0; ph < 6; ph++)
        begin
            if ($urandom_range(3) == 0)
                set_timing(CFG_W'($urandom_range(8)), CFG_W'($urandom_range(8)),
                           CFG_W'($urandom_range(8)), CFG_W'($urandom_range(8)),
                           CFG_W'($urandom_range(8)), CFG_W'($urandom_range(12)),
                           CFG_W'($urandom_range(15)));
            else
                set_timing(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(3)),
                           CFG_W'($urandom_range(3)), CFG_W'($urandom_range(3)),
                           CFG_W'($urandom_range(3)), CFG_W'($urandom_range(5)),
                           CFG_W'($urandom_range(1, 2)));
            calm <= (ph == 2);
            if (ph == 4)
                hold_id <= hold_id + 1;
            for (k = 0; k < ((ph == 2) ? 60 : 18); k++)
            begin
                if (rd_phase == PH_IDLE)
                begin
                    if ($urandom_range(9) < 8)
                    begin
                        st = pick_style();
                        push_sample(1'b1, 1'($urandom_range(1)));
                    end
                    else
                        push_sample(1'b0, 1'($urandom_range(1)));
                end
                else if ($urandom_range(99) < 3)
                    push_sample(1'b1, 1'($urandom_range(1)));
                else
                    push_sample(1'b0, pick_line(st));
            end
        end
        calm <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_id)
        begin
            hold_seen <= hold_id;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                err_count++;
            end
            else
            begin
                seen_exp = expected_results.pop_front();
                if (drive !== seen_exp.drive)
                begin
                    $error("drive: expected %0d, actual %0d", seen_exp.drive, drive);
                    err_count++;
                end
                if (byte_valid !== seen_exp.byte_valid)
                begin
                    $error("byte_valid: expected %0d, actual %0d", seen_exp.byte_valid,
                           byte_valid);
                    err_count++;
                end
                if (byte_value !== seen_exp.byte_value)
                begin
                    $error("byte_value: expected %0h, actual %0h", seen_exp.byte_value,
                           byte_value);
                    err_count++;
                end
                if (last_byte !== seen_exp.last_byte)
                begin
                    $error("last_byte: expected %0d, actual %0d", seen_exp.last_byte,
                           last_byte);
                    err_count++;
                end
                if (done_res !== seen_exp.done_res)
                begin
                    $error("done_res: expected %0d, actual %0d", seen_exp.done_res, done_res);
                    err_count++;
                end
                if (response_ok !== seen_exp.response_ok)
                begin
                    $error("response_ok: expected %0d, actual %0d", seen_exp.response_ok,
                           response_ok);
                    err_count++;
                end
                if (busy_res !== seen_exp.busy_res)
                begin
                    $error("busy_res: expected %0d, actual %0d", seen_exp.busy_res, busy_res);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        reset_reader_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_default_frame();
        test_start_while_busy();
        test_failed_response();
        test_zero_delays();
        test_frame_clamp();
        test_register_extremes();
        test_random_traffic();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/swsr_pkg.sv
hdl/single_wire_sensor_reader_core.sv
verif/single_wire_sensor_reader_core_tb.sv
